[hdl/sbh_pkg.sv]
`default_nettype none
package sbh_pkg;

	localparam int unsigned HashW   = 32;
	localparam int unsigned ShiftW  = 5;
	localparam int unsigned BucketW = 20;
	localparam int unsigned QDepth  = 2;
	localparam int unsigned QPtrW   = 1;
	localparam int unsigned QCntW   = 2;
	localparam int unsigned StepCntW = 5;

	localparam logic [ShiftW-1:0] ShiftStep  = 5'd5;
	localparam logic [ShiftW-1:0] ShiftLimit = 5'd25;
	localparam logic [ShiftW-1:0] ShiftWrap  = 5'd24;
	localparam logic [7:0] LowBase   = 8'h41;
	localparam logic [7:0] HighBase  = 8'h4A;
	localparam logic [7:0] LowerA    = 8'h61;
	localparam logic [7:0] LowerZ    = 8'h7A;
	localparam logic [7:0] CaseDelta = 8'h20;
	localparam logic [StepCntW-1:0] LastStep = 5'd31;

	localparam logic CfgFoldCase    = 1'b0;
	localparam logic CfgBucketCount = 1'b1;

	typedef struct packed {
		logic             push;
		logic [HashW-1:0] hash;
	} sbh_push_t;

	typedef struct packed {
		logic             avail;
		logic [HashW-1:0] hash;
	} sbh_head_t;

	typedef enum logic [1:0] {
		DIV_IDLE = 2'b01,
		DIV_RUN  = 2'b10
	} sbh_div_state_t;

	function automatic logic [ShiftW-1:0] next_shift(input logic [ShiftW-1:0] s);
		logic [ShiftW-1:0] t;
		t = s + ShiftStep;
		if (t >= ShiftLimit)
			t = t - ShiftWrap;
		return t;
	endfunction

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic fold);
		if (fold && c >= LowerA && c <= LowerZ)
			return c - CaseDelta;
		return c;
	endfunction

	function automatic logic [HashW-1:0] weigh(input logic [7:0] c,
			input logic [ShiftW-1:0] s);
		return {{(HashW-8){1'b0}}, c} << s;
	endfunction

endpackage
`default_nettype wire

[hdl/sbh_front.sv]
`default_nettype none
module sbh_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       fold_case,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 key_byte,
	input  wire logic                       carries_byte,
	input  wire logic                       binary_key,
	input  wire logic                       last_byte,
	input  wire logic                       q_full,
	output sbh_pkg::sbh_push_t              push
);
	import sbh_pkg::*;

	logic [HashW-1:0]  sum_q;
	logic [ShiftW-1:0] shift_q;
	logic [7:0]        c0, c1;
	logic [ShiftW-1:0] sh1, sh2;
	logic [HashW-1:0]  add0, add1;
	logic [HashW-1:0]  sum_new;
	logic [ShiftW-1:0] shift_new;
	logic              accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		c0 = fold_char(binary_key ? (LowBase + {4'b0, key_byte[3:0]}) : key_byte, fold_case);
		c1 = fold_char(HighBase + {4'b0, key_byte[7:4]}, fold_case);
		sh1 = next_shift(shift_q);
		sh2 = next_shift(sh1);
		add0 = sum_q + weigh(c0, shift_q);
		add1 = add0 + weigh(c1, sh1);
		if (!carries_byte) begin
			sum_new   = sum_q;
			shift_new = shift_q;
		end else if (binary_key) begin
			sum_new   = add1;
			shift_new = sh2;
		end else begin
			sum_new   = add0;
			shift_new = sh1;
		end
	end

	assign push.push = accept && last_byte;
	assign push.hash = sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			shift_q <= '0;
		end else if (accept) begin
			// clear at end of key
			if (last_byte) begin
				sum_q   <= '0;
				shift_q <= '0;
			end else begin
				sum_q   <= sum_new;
				shift_q <= shift_new;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/sbh_queue.sv]
`default_nettype none
module sbh_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sbh_pkg::sbh_push_t push,
	input  wire logic          pop,
	output logic               full,
	output sbh_pkg::sbh_head_t head
);
	import sbh_pkg::*;

	logic [HashW-1:0] mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full       = (cnt_q == QCntW'(QDepth));
	assign head.avail = (cnt_q != '0);
	assign head.hash  = mem_q[rd_ptr_q];
	assign do_push    = push.push && !full;
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.hash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/sbh_divider.sv]
`default_nettype none
module sbh_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [sbh_pkg::BucketW-1:0] bucket_count,
	input  wire sbh_pkg::sbh_head_t          head,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [sbh_pkg::BucketW-1:0]      bucket_index,
	output logic [sbh_pkg::HashW-1:0]        full_hash
);
	import sbh_pkg::*;

	sbh_div_state_t      state_q;
	logic [StepCntW-1:0] cnt_q;
	logic [BucketW-1:0]  rem_q, d_q;
	logic [HashW-1:0]    dvd_q, hash_q;
	logic [BucketW:0]    trial;
	logic                ge;
	logic [BucketW-1:0]  rem_next;
	logic                out_free, step;

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == DIV_IDLE) && head.avail;
	// hold the final step until the output register frees up
	assign step     = (state_q == DIV_RUN) && ((cnt_q != LastStep) || out_free);

	always_comb begin
		trial    = {rem_q, dvd_q[HashW-1]};
		ge       = trial >= {1'b0, d_q};
		rem_next = ge ? BucketW'(trial - {1'b0, d_q}) : trial[BucketW-1:0];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q  <= head.hash;
			hash_q <= head.hash;
			d_q    <= bucket_count;
			rem_q  <= '0;
		end else if (step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_next;
		end
		if (step && cnt_q == LastStep) begin
			bucket_index <= (d_q == '0) ? '0 : rem_next;
			full_hash    <= hash_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= DIV_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (step && cnt_q == LastStep)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				DIV_IDLE: begin
					if (pop) begin
						cnt_q   <= '0;
						state_q <= DIV_RUN;
					end
				end
				DIV_RUN: begin
					if (step) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LastStep)
							state_q <= DIV_IDLE;
					end
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/string_key_bucket_hash.sv]
`default_nettype none
// channel  | handshake            | payload
// in       | in_valid / in_stall  | key_byte, carries_byte, binary_key, last_byte
// out      | out_valid / out_stall| bucket_index, full_hash
// cfg      | cfg_we               | cfg_index, cfg_data
//
// Key bytes are taken one request per cycle while in_stall is low; the running sum
// is updated in the cycle a byte is accepted. A last byte pushes the sum into a
// two-entry queue. The modulo is a restoring divider, one quotient bit per cycle
// while out_stall does not hold its final step; a queued hash is loaded first.
// in_stall rises only while the queue is full; out_stall holds the output register
// and, on the final divider step, the divider. Reset clears sum, queue and divider.
module string_key_bucket_hash (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [sbh_pkg::BucketW-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  key_byte,
	input  wire logic                        carries_byte,
	input  wire logic                        binary_key,
	input  wire logic                        last_byte,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [sbh_pkg::BucketW-1:0]      bucket_index,
	output logic [sbh_pkg::HashW-1:0]        full_hash
);
	import sbh_pkg::*;

	logic               fold_case_q;
	logic [BucketW-1:0] bucket_count_q;
	sbh_push_t          push;
	sbh_head_t          head;
	logic               q_full, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_case_q    <= 1'b0;
			bucket_count_q <= 20'd101;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgFoldCase:    fold_case_q    <= cfg_data[0];
				CfgBucketCount: bucket_count_q <= cfg_data;
				default:        fold_case_q    <= fold_case_q;
			endcase
		end
	end

	sbh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.fold_case    (fold_case_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_byte     (key_byte),
		.carries_byte (carries_byte),
		.binary_key   (binary_key),
		.last_byte    (last_byte),
		.q_full       (q_full),
		.push         (push)
	);

	sbh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	sbh_divider u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.bucket_count (bucket_count_q),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bucket_index (bucket_index),
		.full_hash    (full_hash)
	);

endmodule
`default_nettype wire

[tb/string_key_bucket_hash_test.sv]
`default_nettype none
module string_key_bucket_hash_test;

	localparam int unsigned Period        = 10;
	localparam int unsigned DrainCycles   = 48;
	localparam int unsigned HoldCycles    = 300;
	localparam int unsigned TimeoutCycles = 500000;

	localparam logic [7:0] CharLowA   = 8'h61;
	localparam logic [7:0] CharLowZ   = 8'h7A;
	localparam logic [7:0] CharUpA    = 8'h41;
	localparam logic [7:0] CaseGap    = 8'h20;
	localparam logic [7:0] LowLetter  = 8'h41;
	localparam logic [7:0] HighLetter = 8'h4A;
	localparam logic [4:0] ShiftStep  = 5'd5;
	localparam logic [4:0] ShiftLimit = 5'd25;
	localparam logic [4:0] ShiftWrap  = 5'd24;

	typedef struct packed {
		logic [7:0] kbyte;
		logic       carries;
		logic       binary;
		logic       last;
	} key_req_t;

	typedef struct packed {
		logic [sbh_pkg::BucketW-1:0] bucket;
		logic [sbh_pkg::HashW-1:0]   hash;
	} key_hash_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = sbh_pkg::CfgFoldCase;
	logic [sbh_pkg::BucketW-1:0] cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [7:0]                  key_byte = '0;
	logic                        carries_byte = 1'b0;
	logic                        binary_key = 1'b0;
	logic                        last_byte = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [sbh_pkg::BucketW-1:0] bucket_index;
	logic [sbh_pkg::HashW-1:0]   full_hash;

	key_req_t  key_reqs[$];
	key_hash_t hashes_due[$];

	// predictor state
	logic                        fold_on = 1'b0;
	logic [sbh_pkg::BucketW-1:0] bucket_mod = 20'd101;
	logic [sbh_pkg::HashW-1:0]   key_sum = '0;
	logic [4:0]                  key_shift = '0;

	int unsigned idle_pct = 10;
	logic        hold_arm = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned error_count = 0;
	int unsigned keys_checked = 0;
	int unsigned bytes_hashed = 0;
	int unsigned in_stall_cycles = 0;
	int unsigned reg_writes = 0;

	string_key_bucket_hash uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_byte     (key_byte),
		.carries_byte (carries_byte),
		.binary_key   (binary_key),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bucket_index (bucket_index),
		.full_hash    (full_hash)
	);

	always #(Period / 2) clk = ~clk;

	task automatic flag_mismatch(input string msg);
		error_count++;
		if (error_count <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	function automatic void mix_char(input logic [7:0] ch);
		logic [7:0] c;
		c = ch;
		if (fold_on && c >= CharLowA && c <= CharLowZ)
			c = c - CaseGap;
		key_sum = key_sum + ({24'd0, c} << key_shift);
		key_shift = key_shift + ShiftStep;
		if (key_shift >= ShiftLimit)
			key_shift = key_shift - ShiftWrap;
	endfunction

	function automatic void absorb_request(input key_req_t r);
		key_hash_t h;
		if (r.carries) begin
			bytes_hashed++;
			if (r.binary) begin
				mix_char(LowLetter + {4'd0, r.kbyte[3:0]});
				mix_char(HighLetter + {4'd0, r.kbyte[7:4]});
			end else begin
				mix_char(r.kbyte);
			end
		end
		if (r.last) begin
			h.hash = key_sum;
			if (bucket_mod == '0)
				h.bucket = '0;
			else
				h.bucket = sbh_pkg::BucketW'(key_sum % {12'd0, bucket_mod});
			hashes_due.push_back(h);
			key_sum = '0;
			key_shift = '0;
		end
	endfunction

	// sender: present queued requests, hold while stalled, idle in bursts
	always @(posedge clk) begin
		key_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == sbh_pkg::CfgFoldCase)
					fold_on = cfg_data[0];
				else
					bucket_mod = cfg_data;
			end
			if (in_valid && in_stall)
				in_stall_cycles++;
			if (in_valid && !in_stall)
				absorb_request({key_byte, carries_byte, binary_key, last_byte});
			if (in_valid && in_stall) begin
				// hold the stalled request
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (key_reqs.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
				gap_left = $urandom_range(0, 3);
				in_valid <= 1'b0;
			end else if (key_reqs.size() != 0) begin
				r = key_reqs.pop_front();
				in_valid <= 1'b1;
				key_byte <= r.kbyte;
				carries_byte <= r.carries;
				binary_key <= r.binary;
				last_byte <= r.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: compare accepted results, stall in bursts and during the hold-off
	always @(posedge clk) begin
		key_hash_t h;
		logic burst;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (hashes_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result bucket %0d hash %h",
						bucket_index, full_hash));
				end else begin
					h = hashes_due.pop_front();
					keys_checked++;
					if (full_hash !== h.hash)
						flag_mismatch($sformatf("full_hash %h, want %h", full_hash, h.hash));
					if (bucket_index !== h.bucket)
						flag_mismatch($sformatf("bucket_index %0d, want %0d",
							bucket_index, h.bucket));
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				burst = 1'b1;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 3);
				burst = 1'b1;
			end else begin
				burst = 1'b0;
			end
			out_stall <= burst || (hold_arm && !hold_done);
		end
	end

	initial begin
		wait (hold_arm);
		repeat (HoldCycles) @(posedge clk);
		hold_done <= 1'b1;
	end

	initial begin
		#(TimeoutCycles * Period);
		$display("string_key_bucket_hash_test: done, errors");
		$finish;
	end

	task automatic push_req(input logic [7:0] b, input logic carries, input logic binary,
			input logic last);
		key_req_t r;
		r.kbyte = b;
		r.carries = carries;
		r.binary = binary;
		r.last = last;
		key_reqs.push_back(r);
	endtask

	task automatic write_reg(input logic idx, input logic [sbh_pkg::BucketW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	// check between edges so the sender's updates at the edge have landed
	task automatic settle();
		while (key_reqs.size() != 0 || in_valid || hashes_due.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// well-formed keys with random content, plus idle items, bare ends and empty keys
	task automatic queue_random_keys(input int unsigned n_items, input int unsigned max_len);
		int unsigned queued;
		int unsigned pick;
		int unsigned len;
		logic key_bin;
		logic mixed;
		logic bare_end;
		logic [7:0] b;
		queued = 0;
		while (queued < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				push_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
				queued++;
			end else if (pick < 12) begin
				push_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
				queued++;
			end else begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, 40);
				else
					len = $urandom_range(1, max_len);
				key_bin = ($urandom_range(0, 3) == 0);
				mixed = ($urandom_range(0, 9) == 0);
				bare_end = ($urandom_range(0, 11) == 0);
				for (int unsigned k = 0; k < len; k++) begin
					if ($urandom_range(0, 1) == 0) begin
						b = CharLowA + 8'($urandom_range(0, 25));
						if ($urandom_range(0, 1) == 0)
							b = b - CaseGap;
					end else begin
						b = 8'($urandom_range(0, 255));
					end
					if (mixed)
						key_bin = 1'($urandom_range(0, 1));
					push_req(b, 1'b1, key_bin, (k == len - 1) && !bare_end);
					queued++;
					if ($urandom_range(0, 19) == 0) begin
						push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
						queued++;
					end
				end
				if (bare_end) begin
					push_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
					queued++;
				end
			end
		end
	endtask

	task automatic run_phase(input logic fold, input logic [sbh_pkg::BucketW-1:0] buckets,
			input int unsigned pct, input int unsigned n_items, input int unsigned max_len);
		write_reg(sbh_pkg::CfgFoldCase, {19'd0, fold});
		write_reg(sbh_pkg::CfgBucketCount, buckets);
		idle_pct <= pct;
		@(negedge clk);
		queue_random_keys(n_items, max_len);
		settle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: no folding, 101 buckets
		push_req(8'h00, 1'b0, 1'b0, 1'b1);
		push_req(8'hFF, 1'b0, 1'b1, 1'b0);
		push_req(CharLowA, 1'b1, 1'b0, 1'b0);
		push_req(CharLowZ, 1'b1, 1'b0, 1'b0);
		push_req(CharUpA, 1'b1, 1'b0, 1'b0);
		push_req(8'h00, 1'b1, 1'b0, 1'b0);
		push_req(8'hFF, 1'b1, 1'b0, 1'b0);
		push_req(8'h80, 1'b1, 1'b0, 1'b0);
		push_req(8'h7F, 1'b1, 1'b0, 1'b1);
		push_req(8'h00, 1'b1, 1'b1, 1'b0);
		push_req(8'hFF, 1'b1, 1'b1, 1'b0);
		push_req(8'h71, 1'b1, 1'b0, 1'b1);
		push_req(8'hFF, 1'b1, 1'b1, 1'b1);
		settle();

		// folding on, zero buckets: letters at the range edges, binary unaffected
		write_reg(sbh_pkg::CfgFoldCase, 20'd1);
		write_reg(sbh_pkg::CfgBucketCount, 20'd0);
		@(negedge clk);
		push_req(CharLowA, 1'b1, 1'b0, 1'b0);
		push_req(CharLowZ, 1'b1, 1'b0, 1'b0);
		push_req(CharLowA - 8'd1, 1'b1, 1'b0, 1'b0);
		push_req(CharLowZ + 8'd1, 1'b1, 1'b0, 1'b0);
		push_req(8'h5A, 1'b1, 1'b0, 1'b0);
		push_req(8'h6D, 1'b1, 1'b0, 1'b1);
		push_req(CharLowA, 1'b1, 1'b1, 1'b0);
		push_req(CharLowZ, 1'b1, 1'b1, 1'b1);
		push_req(8'h00, 1'b0, 1'b0, 1'b1);
		push_req(8'h6B, 1'b1, 1'b0, 1'b0);
		push_req(8'h00, 1'b0, 1'b0, 1'b1);
		settle();

		run_phase(1'b0, 20'd1, 10, 240, 8);
		run_phase(1'b1, 20'd900001, 15, 240, 8);
		run_phase(1'b0, 20'hFFFFF, 0, 240, 12);

		// long receiver hold-off with short keys so the hash queue fills
		hold_arm <= 1'b1;
		run_phase(1'b1, 20'd7, 10, 200, 2);

		for (int unsigned p = 0; p < 3; p++)
			run_phase(1'($urandom_range(0, 1)),
				($urandom_range(0, 1) == 0) ? 20'($urandom_range(1, 64))
					: 20'($urandom_range(1, 900001)),
				$urandom_range(5, 30), 240, 8);

		run_phase(1'($urandom_range(0, 1)), 20'd101, 0, 240, 8);

		$display("covered %0d keys over %0d hashed bytes, %0d register writes",
			keys_checked, bytes_hashed, reg_writes);
		$display("input held back by a full block on %0d cycles", in_stall_cycles);
		if (error_count == 0)
			$display("string_key_bucket_hash_test: done, clean");
		else
			$display("string_key_bucket_hash_test: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
